>>> sv/keyboard_matrix_press_stretcher_assert.svh
// assertion helpers for the press stretcher
`ifndef KEYBOARD_MATRIX_PRESS_STRETCHER_ASSERT_SVH
`define KEYBOARD_MATRIX_PRESS_STRETCHER_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define KMPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("press stretcher assertion failed");

// condition must never be seen out of reset
`define KMPS_NEVER(lbl, clk, rst_n, expr) \
    `KMPS_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define KMPS_ASSERT(lbl, clk, rst_n, prop)
`define KMPS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> sv/kmps_pkg.sv
package kmps_pkg;

    // default matrix width and fixed row count
    localparam int COLUMNS_DEF = 11;
    localparam int ROWS        = 16;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;

    // item kinds
    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_DIGIT = 2'd1,
        K_TICK  = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_FIN
    } t_state;

    // one key position: regular entry and number entry
    typedef struct packed {
        logic       pd;
        logic [3:0] ph;
        logic       dd;
        logic [3:0] dl;
        logic [3:0] dh;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // timing constants and Fn key position
    localparam logic [3:0] HOLD_PLAIN_CLASSIC = 4'd8;
    localparam logic [3:0] HOLD_PLAIN         = 4'd3;
    localparam logic [3:0] DELAY_BUSY         = 4'd3;
    localparam logic [3:0] DELAY_IDLE         = 4'd8;
    localparam logic [3:0] DELAY_CLASSIC      = 4'd0;
    localparam logic [3:0] HOLD_DIGIT_CLASSIC = 4'd8;
    localparam logic [3:0] HOLD_DIGIT         = 4'd12;
    localparam logic [4:0] FN_TAIL_LOAD       = 5'd16;
    localparam logic [15:0] FN_BIT            = 16'h8000;
    localparam logic [3:0] FN_COLUMN          = 4'd7;

    // register map, word index taken from paddr[2]
    localparam int         PADDR_W     = 3;
    localparam logic       REG_CLASSIC = 1'b0;

endpackage

>>> sv/keyboard_matrix_press_stretcher.sv
// Key press stretcher for a COLUMNS x 16 matrix. Every key position keeps a
// regular entry and a number entry in one shared RAM, walked by a single
// read-modify-write update unit. A key event or a column read walks the 16
// rows of its column; a frame tick walks all COLUMNS*16 entries. Events for a
// column at or above COLUMNS are dropped without a walk; reads of such a
// column skip the walk and give all-zero column bits. The
// entry RAM has one read and one write port, one entry per cycle, and that
// port sets the walk length. A column read gives one item on the output; the
// output register lets the next input item be taken while it waits. Reset
// clears all entries at once through per-entry valid flops, so no clearing
// pass is needed. classic_mode sits at byte address 0 of the APB port.
`include "keyboard_matrix_press_stretcher_assert.svh"

module keyboard_matrix_press_stretcher #(
    parameter int COLUMNS = kmps_pkg::COLUMNS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kmps_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_kind,
    input  logic [3:0]                   i_column,
    input  logic [15:0]                  i_key_mask,
    input  logic                         i_pressed,
    input  logic [4:0]                   i_matrix_columns,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [15:0]                  o_column_bits
);

    import kmps_pkg::*;

    localparam int KEY_COUNT = COLUMNS * ROWS;
    localparam int AW        = $clog2(KEY_COUNT);
    localparam int CNT_W     = AW + 1;

    // control registers
    t_state               r_state, n_state;
    t_kind                r_kind;
    logic [COL_W-1:0]     r_col;
    logic [15:0]          r_mask;
    logic                 r_pressed;
    logic                 r_in_range;
    logic [3:0]           r_delay;
    logic [AW-1:0]        r_idx;
    logic                 r_classic;
    logic [CNT_W-1:0]     r_act_cnt;
    logic [4:0]           r_fn_tail;
    logic [KEY_COUNT-1:0] r_vld;
    logic                 r_out_vld;
    logic [15:0]          r_out_bits;
    logic [15:0]          r_bits;

    // update pipeline registers
    logic                 r_p_vld;
    logic                 r_p_ok;
    logic [AW-1:0]        r_p_addr;
    logic [ROW_W-1:0]     r_p_row;

    // combinational signals
    logic                 accept;
    logic                 col_ok;
    logic                 rd_en;
    logic                 last;
    logic                 fin_load;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   ram_q;
    t_entry               e_old, e_new;
    logic                 old_act, new_act, key_on;
    logic                 any_digit;
    logic [15:0]          read_bits;
    logic                 walk_kind;
    logic                 fin_read;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLASSIC) ? {31'd0, r_classic} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_classic <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_CLASSIC) begin
            r_classic <= pwdata[0];
        end
    end

    // handshake and range decode
    assign accept    = i_valid && !o_stall;
    assign col_ok    = {1'b0, i_column} < 5'(COLUMNS);
    assign any_digit = r_act_cnt != '0;

    // walk position
    assign rd_addr = (r_kind == K_TICK) ? r_idx : AW'({r_col, r_idx[ROW_W-1:0]});
    assign last    = (r_kind == K_TICK) ? (r_idx == AW'(KEY_COUNT - 1))
                                        : (r_idx[ROW_W-1:0] == ROW_W'(ROWS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (t_kind'(i_kind) == K_TICK || col_ok) begin
                        n_state = ST_RUN;
                    end else if (t_kind'(i_kind) == K_READ) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_RUN: begin
                if (last) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: n_state = ST_FIN;
            ST_FIN: begin
                if (r_kind != K_READ || !r_out_vld || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall  = (r_state != ST_IDLE) || !i_rst_n;
        rd_en    = r_state == ST_RUN;
        fin_load = (r_state == ST_FIN) && (r_kind == K_READ) && (!r_out_vld || !i_stall);
    end

    // shared entry update unit
    always_comb begin
        e_old = r_p_ok ? t_entry'(ram_q) : '0;
        e_new = e_old;
        case (r_kind)
            K_PLAIN: begin
                if (r_mask[r_p_row]) begin
                    if (r_pressed && !e_old.pd) begin
                        e_new.ph = r_classic ? HOLD_PLAIN_CLASSIC : HOLD_PLAIN;
                    end
                    e_new.pd = r_pressed;
                end
            end
            K_DIGIT: begin
                if (r_mask[r_p_row]) begin
                    if (r_pressed && !e_old.dd) begin
                        e_new.dh = r_classic ? HOLD_DIGIT_CLASSIC : HOLD_DIGIT;
                        e_new.dl = r_delay;
                    end
                    e_new.dd = r_pressed;
                end
            end
            K_TICK: begin
                if (e_old.ph != 4'd0) begin
                    e_new.ph = e_old.ph - 4'd1;
                end
                if (e_old.dl != 4'd0) begin
                    e_new.dl = e_old.dl - 4'd1;
                end else if (e_old.dh != 4'd0) begin
                    e_new.dh = e_old.dh - 4'd1;
                end
            end
            default: e_new = e_old;
        endcase
        old_act = e_old.dd || (e_old.dl != 4'd0) || (e_old.dh != 4'd0);
        new_act = e_new.dd || (e_new.dl != 4'd0) || (e_new.dh != 4'd0);
        key_on  = e_old.pd || (e_old.ph != 4'd0)
                  || ((e_old.dl == 4'd0) && (e_old.dd || (e_old.dh != 4'd0)));
    end

    assign wr_en = r_p_vld && (r_kind != K_READ);

    // final column value with the Fn bit, zero for a column out of range
    always_comb begin
        read_bits = r_bits;
        if (r_col == FN_COLUMN && (r_fn_tail != 5'd0 || any_digit)) begin
            read_bits = read_bits | FN_BIT;
        end
        if (!r_in_range) begin
            read_bits = 16'd0;
        end
    end

    // entry store
    kmps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_p_addr),
        .i_wr_data (e_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= t_kind'(i_kind);
            r_col      <= i_column;
            r_mask     <= i_key_mask;
            r_pressed  <= i_pressed;
            r_in_range <= col_ok && ({1'b0, i_column} < i_matrix_columns);
            if (r_classic) begin
                r_delay <= DELAY_CLASSIC;
            end else if (any_digit || r_fn_tail != 5'd0) begin
                r_delay <= DELAY_BUSY;
            end else begin
                r_delay <= DELAY_IDLE;
            end
        end
    end

    // walk counter and read pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= '0;
        end else if (rd_en) begin
            r_idx <= r_idx + AW'(1);
        end
        r_p_addr <= rd_addr;
        r_p_row  <= r_idx[ROW_W-1:0];
        r_p_ok   <= r_vld[rd_addr];
    end

    // column bit collection
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bits <= '0;
        end else if (r_p_vld && key_on) begin
            r_bits <= r_bits | (16'd1 << r_p_row);
        end
    end

    // control state, valid flops, active count and Fn tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_p_vld   <= 1'b0;
            r_vld     <= '0;
            r_act_cnt <= '0;
            r_fn_tail <= '0;
        end else begin
            r_state <= n_state;
            r_p_vld <= rd_en;
            if (wr_en) begin
                r_vld[r_p_addr] <= 1'b1;
                if (new_act && !old_act) begin
                    r_act_cnt <= r_act_cnt + CNT_W'(1);
                end else if (!new_act && old_act) begin
                    r_act_cnt <= r_act_cnt - CNT_W'(1);
                end
            end
            if (r_state == ST_FIN) begin
                if (r_kind == K_TICK) begin
                    if (!r_classic && any_digit) begin
                        r_fn_tail <= FN_TAIL_LOAD;
                    end else if (r_fn_tail != 5'd0) begin
                        r_fn_tail <= r_fn_tail - 5'd1;
                    end
                end else if (r_kind == K_DIGIT && r_pressed && !r_classic) begin
                    r_fn_tail <= FN_TAIL_LOAD;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
        if (fin_load) begin
            r_out_bits <= read_bits;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_column_bits = r_out_bits;

    // check terms
    assign walk_kind = accept && (t_kind'(i_kind) inside {K_TICK, K_READ});
    assign fin_read  = (r_state == ST_FIN) && (r_kind == K_READ);

    // checks
    `KMPS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_act_cnt <= CNT_W'(KEY_COUNT))
    `KMPS_ASSERT(a_tail_bound, i_clk, i_rst_n, r_fn_tail <= FN_TAIL_LOAD)
    `KMPS_ASSERT(a_walk_starts, i_clk, i_rst_n, walk_kind |=> r_state != ST_IDLE)
    `KMPS_NEVER(a_no_write_on_read, i_clk, i_rst_n, wr_en && r_kind == K_READ)
    `KMPS_ASSERT(a_result_from_read, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(fin_read))

endmodule

>>> sv/kmps_ram.sv
module kmps_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 176,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
